// ===== rtl/tzrsp_pkg.sv =====
// Package for the time-zone rule string parser: parse phase type,
// character codes, field limits and default daylight rules.
// No dependencies; used by tz_rule_string_parser_core.
package tzrsp_pkg;

    // Parse phases; the nine rule numbers occupy consecutive codes.
    typedef enum logic [4:0] {
        PH_NAME1  = 5'd0,
        PH_HSTART = 5'd1,
        PH_HOUR   = 5'd2,
        PH_MIN    = 5'd3,
        PH_SEC    = 5'd4,
        PH_NAME2  = 5'd5,
        PH_F0     = 5'd6,
        PH_F1     = 5'd7,
        PH_F2     = 5'd8,
        PH_F3     = 5'd9,
        PH_F4     = 5'd10,
        PH_F5     = 5'd11,
        PH_F6     = 5'd12,
        PH_F7     = 5'd13,
        PH_F8     = 5'd14,
        PH_WS1    = 5'd15,
        PH_WS2    = 5'd16,
        PH_ERR    = 5'd17
    } t_phase;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Field widths.
    localparam int ACC_W  = 17;
    localparam int OFS_W  = 18;
    localparam int MON_W  = 4;
    localparam int WEEK_W = 4;
    localparam int DAY_W  = 5;
    localparam int TIME_W = 17;

    // Field limits.
    localparam logic [19:0] LIM_HOUR   = 20'd23;
    localparam logic [19:0] LIM_MINSEC = 20'd59;
    localparam logic [19:0] MAX_MONTH  = 20'd12;
    localparam logic [19:0] MAX_WEEK   = 20'd4;
    localparam logic [19:0] MAX_WDAY   = 20'd6;
    localparam logic [19:0] MAX_MDAY   = 20'd31;
    localparam logic [19:0] MAX_TIME   = 20'd86399;
    localparam logic [19:0] MAX_SHIFT  = 20'd86400;

    // Seconds per offset unit.
    localparam logic [OFS_W-1:0] SEC_PER_HOUR = 18'd3600;
    localparam logic [OFS_W-1:0] SEC_PER_MIN  = 18'd60;

    // Default switch rules when the daylight name has no rule list.
    localparam logic [MON_W-1:0]         DEF_START_MONTH = 4'd4;
    localparam logic signed [WEEK_W-1:0] DEF_START_WEEK  = 4'sd1;
    localparam logic [TIME_W-1:0]        DEF_START_TIME  = 17'd3600;
    localparam logic [MON_W-1:0]         DEF_END_MONTH   = 4'd10;
    localparam logic signed [WEEK_W-1:0] DEF_END_WEEK    = -4'sd1;
    localparam logic [TIME_W-1:0]        DEF_END_TIME    = 17'd7200;
    localparam logic [TIME_W-1:0]        DEF_SHIFT       = 17'd3600;

endpackage

// ===== rtl/tz_rule_string_parser_core.sv =====
// Top level of the time-zone rule string parser: a one-character-per-cycle
// parse stage and the registered result item.
// Depends on tzrsp_pkg.
//
// Usage: characters of a rule string enter on the input channel (i_valid,
// o_ready, i_ch), one item per character. A NUL that ends the string
// produces exactly one result item on the output channel (o_valid,
// i_ready, o_status and the offset and rule fields); other characters,
// and a NUL taken by a missing number, bad delimiter or low value, produce
// none. After the item the parser is back at the start of a new string.
// The registered result item is valid in the cycle after the NUL is taken.
// Throughput: one character per cycle unless a result waits with i_ready
// low; each character takes one pass of the parse logic between the state
// registers and the result register, so strings may follow without gaps.
// Reset: i_rst_n low clears the parse state to the start of the first name
// and drops o_valid.
// Stall: while a result waits with i_ready low, o_ready is low and no
// character is taken; o_ready follows i_ready combinationally, so input
// resumes in the same cycle that the waiting result is taken.
module tz_rule_string_parser_core
    import tzrsp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_ch,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_status,
    output logic signed [OFS_W-1:0]  o_std_offset,
    output logic                     o_dst_on,
    output logic [MON_W-1:0]         o_start_month,
    output logic signed [WEEK_W-1:0] o_start_week,
    output logic [DAY_W-1:0]         o_start_day,
    output logic [TIME_W-1:0]        o_start_time,
    output logic [MON_W-1:0]         o_end_month,
    output logic signed [WEEK_W-1:0] o_end_week,
    output logic [DAY_W-1:0]         o_end_day,
    output logic [TIME_W-1:0]        o_end_time,
    output logic [TIME_W-1:0]        o_dst_shift
);

    // Parse state registers.
    t_phase                     r_phase, n_phase;
    logic [ACC_W-1:0]           r_acc, n_acc;
    logic                       r_neg, n_neg;
    logic                       r_seen, n_seen;
    logic signed [OFS_W-1:0]    r_offset, n_offset;
    logic                       r_dst, n_dst;
    logic [MON_W-1:0]           r_month0, n_month0, r_month1, n_month1;
    logic signed [WEEK_W-1:0]   r_week0, n_week0, r_week1, n_week1;
    logic [DAY_W-1:0]           r_day0, n_day0, r_day1, n_day1;
    logic [TIME_W-1:0]          r_time0, n_time0, r_time1, n_time1;
    logic [TIME_W-1:0]          r_shift, n_shift;

    // Result register.
    logic                       r_out_valid;
    logic                       r_status;
    logic signed [OFS_W-1:0]    r_std_offset;
    logic                       r_dst_on;
    logic [MON_W-1:0]           r_start_month, r_end_month;
    logic signed [WEEK_W-1:0]   r_start_week, r_end_week;
    logic [DAY_W-1:0]           r_start_day, r_end_day;
    logic [TIME_W-1:0]          r_start_time, r_end_time;
    logic [TIME_W-1:0]          r_dst_shift;

    // Working values of the parse pass.
    t_phase                     w_phase;
    logic                       w_go;
    logic                       w_emit;
    logic [ACC_W-1:0]           w_acc;
    logic                       w_neg;
    logic                       w_seen;
    logic signed [OFS_W-1:0]    w_offset;
    logic                       w_dst;
    logic [MON_W-1:0]           w_month0, w_month1;
    logic signed [WEEK_W-1:0]   w_week0, w_week1;
    logic [DAY_W-1:0]           w_day0, w_day1;
    logic [TIME_W-1:0]          w_time0, w_time1;
    logic [TIME_W-1:0]          w_shift;

    logic                       in_fire;
    logic                       is_digit;
    logic                       is_letter;
    logic                       is_sign;
    logic [3:0]                 digit_val;
    logic [19:0]                acc_next;
    logic [19:0]                lim;
    logic [OFS_W-1:0]           term;
    logic [3:0]                 fk;
    logic                       fr;
    logic signed [WEEK_W-1:0]   fweek;
    logic                       lo_one;
    logic [WEEK_W-1:0]          acc_week;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    // Character classes.
    assign is_digit  = (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign is_letter = ((i_ch >= 8'h41) && (i_ch <= 8'h5A)) ||
                       ((i_ch >= 8'h61) && (i_ch <= 8'h7A));
    assign is_sign   = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
    assign digit_val = i_ch[3:0];

    // Decimal accumulation: n*10 + d, wide enough to see any overflow.
    assign acc_next = ({3'd0, r_acc} << 3) + ({3'd0, r_acc} << 1) + 20'(digit_val);

    // Rule number index and its rule half for the field phases.
    always_comb begin
        unique case (r_phase)
            PH_WS1:  fk = 4'd1;
            PH_WS2:  fk = 4'd5;
            default: fk = 4'(5'(r_phase) - 5'(PH_F0));
        endcase
        fr       = (fk >= 4'd4) && (fk <= 4'd7);
        fweek    = fr ? r_week1 : r_week0;
        acc_week = r_acc[WEEK_W-1:0];
        // Largest magnitude allowed for this rule number.
        unique case (fk[1:0])
            2'd0:    lim = (fk == 4'd8) ? MAX_SHIFT : MAX_MONTH;
            2'd1:    lim = MAX_WEEK;
            2'd2:    lim = (fweek != '0) ? MAX_WDAY : MAX_MDAY;
            default: lim = MAX_TIME;
        endcase
        // Fields whose smallest value is one rather than zero.
        lo_one = ((fk[1:0] == 2'd0) && (fk != 4'd8)) ||
                 ((fk[1:0] == 2'd2) && (fweek == '0));
    end

    // One parse pass over the current character. A phase may hand the
    // same character on to the following phase while w_go stays high.
    always_comb begin
        w_phase  = r_phase;
        w_go     = 1'b1;
        w_emit   = 1'b0;
        w_acc    = r_acc;
        w_neg    = r_neg;
        w_seen   = r_seen;
        w_offset = r_offset;
        w_dst    = r_dst;
        w_month0 = r_month0;
        w_month1 = r_month1;
        w_week0  = r_week0;
        w_week1  = r_week1;
        w_day0   = r_day0;
        w_day1   = r_day1;
        w_time0  = r_time0;
        w_time1  = r_time1;
        w_shift  = r_shift;
        term     = '0;

        // First name: letters are skipped; a NUL ends the string, else the offset starts.
        if (w_phase == PH_NAME1) begin
            if (is_letter) begin
                w_go = 1'b0;
            end else if (i_ch == CH_NUL) begin
                w_emit = 1'b1;
                w_go   = 1'b0;
            end else begin
                w_phase = PH_HSTART;
            end
        end

        // Optional sign of the offset.
        if (w_go && w_phase == PH_HSTART) begin
            w_phase = PH_HOUR;
            if (is_sign) begin
                w_neg = (i_ch == CH_MINUS);
                w_go  = 1'b0;
            end
        end

        // Hours, minutes and seconds of the offset.
        if (w_go && (w_phase == PH_HOUR || w_phase == PH_MIN || w_phase == PH_SEC)) begin
            if (is_digit) begin
                w_go   = 1'b0;
                w_seen = 1'b1;
                w_acc  = acc_next[ACC_W-1:0];
                if (acc_next > ((w_phase == PH_HOUR) ? LIM_HOUR : LIM_MINSEC)) begin
                    w_phase = PH_ERR;
                end
            end else if (!w_seen) begin
                // A missing number consumes the character, even a NUL.
                w_phase = PH_ERR;
                w_go    = 1'b0;
            end else begin
                unique case (w_phase)
                    PH_HOUR: term = OFS_W'(w_acc[5:0]) * SEC_PER_HOUR;
                    PH_MIN:  term = OFS_W'(w_acc[5:0]) * SEC_PER_MIN;
                    default: term = OFS_W'(w_acc[5:0]);
                endcase
                w_offset = w_offset + $signed(term);
                w_acc    = '0;
                w_seen   = 1'b0;
                if (i_ch == CH_COLON && w_phase != PH_SEC) begin
                    w_phase = (w_phase == PH_HOUR) ? PH_MIN : PH_SEC;
                    w_go    = 1'b0;
                end else begin
                    if (w_neg) begin
                        w_offset = -w_offset;
                    end
                    w_neg = 1'b0;
                    if (i_ch == CH_NUL) begin
                        w_emit = 1'b1;
                        w_go   = 1'b0;
                    end else begin
                        w_dst   = 1'b1;
                        w_phase = PH_NAME2;
                    end
                end
            end
        end

        // Daylight name, then the end or a rule list.
        if (w_go && w_phase == PH_NAME2) begin
            if (is_letter) begin
                w_go = 1'b0;
            end else if (i_ch == CH_COMMA) begin
                w_phase = PH_F0;
                w_go    = 1'b0;
            end else if (i_ch == CH_NUL) begin
                w_month0 = DEF_START_MONTH;
                w_week0  = DEF_START_WEEK;
                w_day0   = '0;
                w_time0  = DEF_START_TIME;
                w_month1 = DEF_END_MONTH;
                w_week1  = DEF_END_WEEK;
                w_day1   = '0;
                w_time1  = DEF_END_TIME;
                w_shift  = DEF_SHIFT;
                w_emit   = 1'b1;
                w_go     = 1'b0;
            end else begin
                w_phase = PH_ERR;
            end
        end

        // The nine rule numbers; only reached directly from the state.
        // A missing number, a bad delimiter or a value below range consumes
        // the character, even a NUL.
        if (w_go && ((w_phase >= PH_F0 && w_phase <= PH_F8) ||
                     w_phase == PH_WS1 || w_phase == PH_WS2)) begin
            if (!w_seen && w_phase != PH_WS1 && w_phase != PH_WS2 &&
                (fk == 4'd1 || fk == 4'd5) && is_sign) begin
                w_neg   = (i_ch == CH_MINUS);
                w_phase = (fk == 4'd1) ? PH_WS1 : PH_WS2;
                w_go    = 1'b0;
            end else if (is_digit) begin
                w_go   = 1'b0;
                w_seen = 1'b1;
                w_acc  = acc_next[ACC_W-1:0];
                if (acc_next > lim) begin
                    w_phase = PH_ERR;
                end
            end else if (!w_seen || i_ch != ((fk == 4'd8) ? CH_NUL : CH_COMMA)) begin
                w_phase = PH_ERR;
                w_go    = 1'b0;
            end else if (lo_one && w_acc == '0) begin
                w_phase = PH_ERR;
                w_go    = 1'b0;
            end else begin
                unique case (fk)
                    4'd0:    w_month0 = w_acc[MON_W-1:0];
                    4'd1:    w_week0  = $signed(w_neg ? -acc_week : acc_week);
                    4'd2:    w_day0   = w_acc[DAY_W-1:0];
                    4'd3:    w_time0  = w_acc[TIME_W-1:0];
                    4'd4:    w_month1 = w_acc[MON_W-1:0];
                    4'd5:    w_week1  = $signed(w_neg ? -acc_week : acc_week);
                    4'd6:    w_day1   = w_acc[DAY_W-1:0];
                    4'd7:    w_time1  = w_acc[TIME_W-1:0];
                    default: w_shift  = w_acc[TIME_W-1:0];
                endcase
                w_acc  = '0;
                w_seen = 1'b0;
                w_neg  = 1'b0;
                w_go   = 1'b0;
                if (fk == 4'd8) begin
                    w_emit = 1'b1;
                end else begin
                    w_phase = t_phase'(5'(PH_F0) + 5'(fk) + 5'd1);
                end
            end
        end

        // Error: characters are ignored until the terminating NUL.
        if (w_go && w_phase == PH_ERR) begin
            if (i_ch == CH_NUL) begin
                w_emit = 1'b1;
            end
        end
    end

    // Next state: an emitted result returns the parser to its start.
    always_comb begin
        if (w_emit) begin
            n_phase  = PH_NAME1;
            n_acc    = '0;
            n_neg    = 1'b0;
            n_seen   = 1'b0;
            n_offset = '0;
            n_dst    = 1'b0;
            n_month0 = '0;
            n_month1 = '0;
            n_week0  = '0;
            n_week1  = '0;
            n_day0   = '0;
            n_day1   = '0;
            n_time0  = '0;
            n_time1  = '0;
            n_shift  = '0;
        end else begin
            n_phase  = w_phase;
            n_acc    = w_acc;
            n_neg    = w_neg;
            n_seen   = w_seen;
            n_offset = w_offset;
            n_dst    = w_dst;
            n_month0 = w_month0;
            n_month1 = w_month1;
            n_week0  = w_week0;
            n_week1  = w_week1;
            n_day0   = w_day0;
            n_day1   = w_day1;
            n_time0  = w_time0;
            n_time1  = w_time1;
            n_shift  = w_shift;
        end
    end

    // Parse state registers advance on each accepted character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_NAME1;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_seen   <= 1'b0;
            r_offset <= '0;
            r_dst    <= 1'b0;
            r_month0 <= '0;
            r_month1 <= '0;
            r_week0  <= '0;
            r_week1  <= '0;
            r_day0   <= '0;
            r_day1   <= '0;
            r_time0  <= '0;
            r_time1  <= '0;
            r_shift  <= '0;
        end else if (in_fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_seen   <= n_seen;
            r_offset <= n_offset;
            r_dst    <= n_dst;
            r_month0 <= n_month0;
            r_month1 <= n_month1;
            r_week0  <= n_week0;
            r_week1  <= n_week1;
            r_day0   <= n_day0;
            r_day1   <= n_day1;
            r_time0  <= n_time0;
            r_time1  <= n_time1;
            r_shift  <= n_shift;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= w_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; an error result carries only the status bit.
    always_ff @(posedge i_clk) begin
        if (in_fire && w_emit) begin
            r_status      <= (w_phase == PH_ERR);
            r_std_offset  <= '0;
            r_dst_on      <= 1'b0;
            r_start_month <= '0;
            r_start_week  <= '0;
            r_start_day   <= '0;
            r_start_time  <= '0;
            r_end_month   <= '0;
            r_end_week    <= '0;
            r_end_day     <= '0;
            r_end_time    <= '0;
            r_dst_shift   <= '0;
            if (w_phase != PH_ERR) begin
                r_std_offset <= w_offset;
                r_dst_on     <= w_dst;
                if (w_dst) begin
                    r_start_month <= w_month0;
                    r_start_week  <= w_week0;
                    r_start_day   <= w_day0;
                    r_start_time  <= w_time0;
                    r_end_month   <= w_month1;
                    r_end_week    <= w_week1;
                    r_end_day     <= w_day1;
                    r_end_time    <= w_time1;
                    r_dst_shift   <= w_shift;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_std_offset  = r_std_offset;
    assign o_dst_on      = r_dst_on;
    assign o_start_month = r_start_month;
    assign o_start_week  = r_start_week;
    assign o_start_day   = r_start_day;
    assign o_start_time  = r_start_time;
    assign o_end_month   = r_end_month;
    assign o_end_week    = r_end_week;
    assign o_end_day     = r_end_day;
    assign o_end_time    = r_end_time;
    assign o_dst_shift   = r_dst_shift;

endmodule

// ===== tb/tz_rule_string_parser_core_tb.sv =====
// Self-checking testbench for tz_rule_string_parser_core: directed rule strings, then random
// well-formed and broken strings under several valid/ready idling patterns.
// Depends on tzrsp_pkg and the parser RTL; no files or arguments are read.
module tz_rule_string_parser_core_tb;
    import tzrsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Character codes used by the string generator and the expected-rule model.
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam int RESET_CYCLES  = 7;
    localparam int CHARS_PER_MIX = 275;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    // One parsed rule as it leaves the output channel.
    typedef struct {
        logic                     status;
        logic signed [OFS_W-1:0]  std_offset;
        logic                     dst_on;
        logic [MON_W-1:0]         start_month;
        logic signed [WEEK_W-1:0] start_week;
        logic [DAY_W-1:0]         start_day;
        logic [TIME_W-1:0]        start_time;
        logic [MON_W-1:0]         end_month;
        logic signed [WEEK_W-1:0] end_week;
        logic [DAY_W-1:0]         end_day;
        logic [TIME_W-1:0]        end_time;
        logic [TIME_W-1:0]        dst_shift;
    } t_zone_rule;

    // One row of the directed string table.
    typedef struct {
        string      text;
        bit         typed;
        t_zone_rule want;
    } t_dir_row;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic [7:0]               i_ch    = '0;
    logic                     i_ready = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic                     o_status;
    logic signed [OFS_W-1:0]  o_std_offset;
    logic                     o_dst_on;
    logic [MON_W-1:0]         o_start_month;
    logic signed [WEEK_W-1:0] o_start_week;
    logic [DAY_W-1:0]         o_start_day;
    logic [TIME_W-1:0]        o_start_time;
    logic [MON_W-1:0]         o_end_month;
    logic signed [WEEK_W-1:0] o_end_week;
    logic [DAY_W-1:0]         o_end_day;
    logic [TIME_W-1:0]        o_end_time;
    logic [TIME_W-1:0]        o_dst_shift;

    // Expected-rule model state.
    t_phase                   pz_phase;
    int unsigned              pz_acc;
    bit                       pz_neg;
    bit                       pz_seen;
    bit                       pz_err;
    bit                       pz_dst;
    logic signed [OFS_W-1:0]  pz_ofs;
    logic [MON_W-1:0]         pz_month[2];
    logic signed [WEEK_W-1:0] pz_week[2];
    logic [DAY_W-1:0]         pz_day[2];
    logic [TIME_W-1:0]        pz_time[2];
    logic [TIME_W-1:0]        pz_shift;

    t_zone_rule  pending_rules[$];
    t_zone_rule  want_rule;
    t_dir_row    dir_rows[$];
    logic [7:0]  rule_text[$];
    int          mismatch_count = 0;
    int          chars_sent     = 0;
    int          dir_chars      = 0;
    int          stall_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    tz_rule_string_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ch          (i_ch),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_std_offset  (o_std_offset),
        .o_dst_on      (o_dst_on),
        .o_start_month (o_start_month),
        .o_start_week  (o_start_week),
        .o_start_day   (o_start_day),
        .o_start_time  (o_start_time),
        .o_end_month   (o_end_month),
        .o_end_week    (o_end_week),
        .o_end_day     (o_end_day),
        .o_end_time    (o_end_time),
        .o_dst_shift   (o_dst_shift)
    );

    // Free-running 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    // Return the model to the start of a new string.
    function automatic void zone_clear();
        pz_phase = PH_NAME1;
        pz_acc   = 0;
        pz_neg   = 1'b0;
        pz_seen  = 1'b0;
        pz_err   = 1'b0;
        pz_dst   = 1'b0;
        pz_ofs   = '0;
        pz_shift = '0;
        for (int r = 0; r < 2; r++) begin
            pz_month[r] = '0;
            pz_week[r]  = '0;
            pz_day[r]   = '0;
            pz_time[r]  = '0;
        end
    endfunction

    function automatic void zone_fail();
        pz_phase = PH_ERR;
        pz_err   = 1'b1;
    endfunction

    // Build the rule that a NUL produces, then start over.
    function automatic t_zone_rule zone_emit();
        t_zone_rule res;
        res = '{default: '0};
        if (pz_err) begin
            res.status = 1'b1;
        end else begin
            res.std_offset = pz_ofs;
            res.dst_on     = pz_dst;
            if (pz_dst) begin
                res.start_month = pz_month[0];
                res.start_week  = pz_week[0];
                res.start_day   = pz_day[0];
                res.start_time  = pz_time[0];
                res.end_month   = pz_month[1];
                res.end_week    = pz_week[1];
                res.end_day     = pz_day[1];
                res.end_time    = pz_time[1];
                res.dst_shift   = pz_shift;
            end
        end
        zone_clear();
        return res;
    endfunction

    // Largest magnitude allowed for rule number k (0..8).
    function automatic int unsigned rule_field_max(input int unsigned k);
        case (k % 4)
            0: return (k == 8) ? 86400 : 12;
            1: return 4;
            2: return (pz_week[(k / 4) % 2] != 0) ? 6 : 31;
            default: return 86399;
        endcase
    endfunction

    // Advance the model by one character; returns 1 when a rule item is produced.
    function automatic bit zone_parse_char(input logic [7:0] c, output t_zone_rule res);
        bit          is_dig;
        bit          redo;
        bit          emitted;
        bit          signed_done;
        int unsigned k;
        int unsigned r;
        int unsigned lim;
        int unsigned unit;
        int          v;
        int          lo;
        int          hi;
        is_dig  = (c >= CH_DIGIT0 && c <= CH_DIGIT9);
        emitted = 1'b0;
        res     = '{default: '0};
        redo    = 1'b1;
        while (redo) begin
            redo = 1'b0;
            if (pz_phase == PH_NAME1) begin
                if (c == CH_NUL) begin
                    res = zone_emit();
                    emitted = 1'b1;
                end else if (!is_letter(c)) begin
                    pz_phase = PH_HSTART;
                    redo = 1'b1;
                end
            end else if (pz_phase == PH_HSTART) begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    pz_neg = (c == CH_MINUS);
                end else begin
                    redo = 1'b1;
                end
                pz_phase = PH_HOUR;
            end else if (pz_phase inside {PH_HOUR, PH_MIN, PH_SEC}) begin
                lim  = (pz_phase == PH_HOUR) ? 23 : 59;
                unit = (pz_phase == PH_HOUR) ? 3600 : (pz_phase == PH_MIN) ? 60 : 1;
                if (is_dig) begin
                    pz_acc  = pz_acc * 10 + (c - CH_DIGIT0);
                    pz_seen = 1'b1;
                    if (pz_acc > lim) zone_fail();
                end else if (!pz_seen) begin
                    // A missing number swallows the character, even a NUL.
                    zone_fail();
                end else begin
                    pz_ofs  = pz_ofs + OFS_W'(pz_acc * unit);
                    pz_acc  = 0;
                    pz_seen = 1'b0;
                    if (c == CH_COLON && pz_phase != PH_SEC) begin
                        pz_phase = t_phase'(pz_phase + 1);
                    end else begin
                        // The sign covers hours, minutes and seconds together.
                        if (pz_neg) pz_ofs = -pz_ofs;
                        pz_neg = 1'b0;
                        if (c == CH_NUL) begin
                            res = zone_emit();
                            emitted = 1'b1;
                        end else begin
                            pz_dst   = 1'b1;
                            pz_phase = PH_NAME2;
                            redo     = 1'b1;
                        end
                    end
                end
            end else if (pz_phase == PH_NAME2) begin
                if (c == CH_COMMA) begin
                    pz_phase = PH_F0;
                end else if (c == CH_NUL) begin
                    // Daylight name alone selects the fixed default rules.
                    pz_month[0] = 4;
                    pz_week[0]  = 1;
                    pz_day[0]   = 0;
                    pz_time[0]  = 3600;
                    pz_month[1] = 10;
                    pz_week[1]  = -1;
                    pz_day[1]   = 0;
                    pz_time[1]  = 7200;
                    pz_shift    = 3600;
                    res = zone_emit();
                    emitted = 1'b1;
                end else if (!is_letter(c)) begin
                    zone_fail();
                    redo = 1'b1;
                end
            end else if (pz_phase >= PH_F0 && pz_phase <= PH_WS2) begin
                signed_done = pz_phase inside {PH_WS1, PH_WS2};
                k = (pz_phase == PH_WS1) ? 1 : (pz_phase == PH_WS2) ? 5 : pz_phase - PH_F0;
                r = (k / 4) % 2;
                if (!pz_seen && !signed_done && (k == 1 || k == 5)
                        && (c == CH_PLUS || c == CH_MINUS)) begin
                    pz_neg   = (c == CH_MINUS);
                    pz_phase = (k == 1) ? PH_WS1 : PH_WS2;
                end else if (is_dig) begin
                    pz_acc  = pz_acc * 10 + (c - CH_DIGIT0);
                    pz_seen = 1'b1;
                    if (pz_acc > rule_field_max(k)) zone_fail();
                end else if (!pz_seen || c != ((k < 8) ? CH_COMMA : CH_NUL)) begin
                    zone_fail();
                end else begin
                    v  = pz_neg ? -int'(pz_acc) : int'(pz_acc);
                    hi = int'(rule_field_max(k));
                    if (k % 4 == 1) lo = -4;
                    else if (k % 4 == 0 && k != 8) lo = 1;
                    else if (k % 4 == 2 && pz_week[r] == 0) lo = 1;
                    else lo = 0;
                    if (v < lo || v > hi) begin
                        zone_fail();
                    end else begin
                        case (k % 4)
                            0: if (k == 8) pz_shift = TIME_W'(v); else pz_month[r] = MON_W'(v);
                            1: pz_week[r] = WEEK_W'(v);
                            2: pz_day[r] = DAY_W'(v);
                            default: pz_time[r] = TIME_W'(v);
                        endcase
                        pz_acc  = 0;
                        pz_seen = 1'b0;
                        pz_neg  = 1'b0;
                        if (k == 8) begin
                            res = zone_emit();
                            emitted = 1'b1;
                        end else begin
                            pz_phase = t_phase'(PH_F0 + k + 1);
                        end
                    end
                end
            end else begin
                // Error state: everything up to a NUL is dropped.
                zone_fail();
                if (c == CH_NUL) begin
                    res = zone_emit();
                    emitted = 1'b1;
                end
            end
        end
        return emitted;
    endfunction

    // Typed expectations for the directed table.
    function automatic t_zone_rule err_rule();
        t_zone_rule res;
        res = '{default: '0};
        res.status = 1'b1;
        return res;
    endfunction

    function automatic t_zone_rule no_dst(input int ofs);
        t_zone_rule res;
        res = '{default: '0};
        res.std_offset = OFS_W'(ofs);
        return res;
    endfunction

    function automatic t_zone_rule default_dst(input int ofs);
        t_zone_rule res;
        res = no_dst(ofs);
        res.dst_on      = 1'b1;
        res.start_month = 4;
        res.start_week  = 1;
        res.start_time  = 3600;
        res.end_month   = 10;
        res.end_week    = -1;
        res.end_time    = 7200;
        res.dst_shift   = 3600;
        return res;
    endfunction

    task automatic add_row(input string text, input bit typed, input t_zone_rule want);
        t_dir_row row;
        row.text  = text;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Random value, mostly in range, with extremes and a few just past the top.
    function automatic int pick_val(input int lo, input int hi);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return hi + 1 + int'($urandom_range(0, 2));
        if (roll < 12) return lo;
        if (roll < 22) return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'(CH_UPPER_A + $urandom_range(0, 25));
        return 8'(CH_LOWER_A + $urandom_range(0, 25));
    endfunction

    // Append a decimal number, sometimes with a leading zero.
    task automatic put_num(input int v);
        string digits;
        digits = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0) rule_text.push_back(CH_DIGIT0);
        for (int i = 0; i < digits.len(); i++) rule_text.push_back(digits[i]);
    endtask

    // Append a week number with an optional sign; returns the drawn value (a minus may negate it).
    task automatic put_week(output int w);
        w = pick_val(-4, 4);
        if (w < 0) begin
            rule_text.push_back(CH_MINUS);
        end else if ($urandom_range(0, 3) == 0) begin
            rule_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        end
        put_num((w < 0) ? -w : w);
    endtask

    task automatic put_rule_part();
        int w;
        put_num(pick_val(1, 12));
        rule_text.push_back(CH_COMMA);
        put_week(w);
        rule_text.push_back(CH_COMMA);
        put_num((w == 0) ? pick_val(1, 31) : pick_val(0, 6));
        rule_text.push_back(CH_COMMA);
        put_num(pick_val(0, 86399));
        rule_text.push_back(CH_COMMA);
    endtask

    // Random rule string: mostly well formed, some pure noise, some damaged.
    task automatic make_random_rule();
        int idx;
        rule_text.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) rule_text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 4)) rule_text.push_back(rand_letter());
            if ($urandom_range(0, 7) != 0) begin
                case ($urandom_range(0, 2))
                    1: rule_text.push_back(CH_PLUS);
                    2: rule_text.push_back(CH_MINUS);
                    default: ;
                endcase
                put_num(pick_val(0, 23));
                if ($urandom_range(0, 99) < 60) begin
                    rule_text.push_back(CH_COLON);
                    put_num(pick_val(0, 59));
                    if ($urandom_range(0, 1)) begin
                        rule_text.push_back(CH_COLON);
                        put_num(pick_val(0, 59));
                    end
                end
                if ($urandom_range(0, 99) < 75) begin
                    repeat ($urandom_range(0, 4)) rule_text.push_back(rand_letter());
                    if ($urandom_range(0, 99) < 70) begin
                        rule_text.push_back(CH_COMMA);
                        put_rule_part();
                        put_rule_part();
                        put_num(pick_val(0, 86400));
                    end
                end
            end
            // Damage about one string in five.
            if ($urandom_range(0, 4) == 0) begin
                if (rule_text.size() == 0) begin
                    rule_text.push_back(8'($urandom_range(0, 255)));
                end else begin
                    idx = $urandom_range(0, rule_text.size() - 1);
                    case ($urandom_range(0, 2))
                        0: rule_text[idx] = 8'($urandom_range(0, 255));
                        1: rule_text.insert(idx, 8'($urandom_range(0, 255)));
                        default: while (rule_text.size() > idx) void'(rule_text.pop_back());
                    endcase
                end
            end
        end
        rule_text.push_back(CH_NUL);
    endtask

    // Offer one character item and record the rule it is expected to produce.
    task automatic send_char(input logic [7:0] c, input bit typed, input t_zone_rule want);
        t_zone_rule res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (!o_ready);
        if (zone_parse_char(c, res)) pending_rules.push_back(typed ? want : res);
        chars_sent++;
    endtask

    // Send the current string; a NUL swallowed by an error needs another NUL.
    task automatic send_rule_text(input bit typed, input t_zone_rule want);
        foreach (rule_text[i]) send_char(rule_text[i], typed, want);
        while (pz_phase != PH_NAME1) send_char(CH_NUL, typed, want);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string fname, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", fname, got, want));
    endtask

    // Result side: compare each accepted rule item and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rules.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want_rule = pending_rules.pop_front();
                check_field("status", o_status, want_rule.status);
                check_field("std_offset", o_std_offset, want_rule.std_offset);
                check_field("dst_on", o_dst_on, want_rule.dst_on);
                check_field("start_month", o_start_month, want_rule.start_month);
                check_field("start_week", o_start_week, want_rule.start_week);
                check_field("start_day", o_start_day, want_rule.start_day);
                check_field("start_time", o_start_time, want_rule.start_time);
                check_field("end_month", o_end_month, want_rule.end_month);
                check_field("end_week", o_end_week, want_rule.end_week);
                check_field("end_day", o_end_day, want_rule.end_day);
                check_field("end_time", o_end_time, want_rule.end_time);
                check_field("dst_shift", o_dst_shift, want_rule.dst_shift);
            end
        end
        i_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("tz_rule_string_parser_core test failed");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random strings in four idling mixes.
    initial begin
        zone_clear();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row("", 1'b1, no_dst(0));
        add_row("UTC", 1'b1, no_dst(0));
        add_row("7", 1'b1, no_dst(25200));
        add_row("EST5EDT", 1'b1, default_dst(18000));
        add_row("A-0:30", 1'b1, no_dst(-1800));
        add_row("Zz+23:59:59", 1'b1, no_dst(86399));
        add_row("Q-23:59:59W", 1'b1, default_dst(-86399));
        add_row("B24", 1'b1, err_rule());
        add_row("B1:60", 1'b1, err_rule());
        add_row("B+", 1'b1, err_rule());
        add_row("B1:2:3:4", 1'b1, err_rule());
        add_row("X1Y;", 1'b1, err_rule());
        add_row("X0Y,12,-4,6,86399,1,0,31,0,86400", 1'b0, err_rule());
        add_row("X1Y,1,+4,0,0,12,4,0,0,0", 1'b0, err_rule());
        add_row("X1,1,-1,0,0,1,1,1,0,3600", 1'b0, err_rule());
        add_row("X1Y,13,1,1,1,1,1,1,1,1", 1'b1, err_rule());
        add_row("X1Y,0,1,1,1,1,1,1,1,1", 1'b1, err_rule());
        add_row("X1Y,+1,1,1,1,1,1,1,1,1", 1'b1, err_rule());
        add_row("X1Y,1,-5,1,1,1,1,1,1,1", 1'b1, err_rule());
        add_row("X1Y,1,1,7,1,1,1,1,1,1", 1'b1, err_rule());
        add_row("X1Y,1,0,0,1,1,1,1,1,1", 1'b1, err_rule());
        add_row("X1Y,1,1,1,86400,1,1,1,1,1", 1'b1, err_rule());
        add_row("X1Y,1,1,1,1,1,1,1,1,86401", 1'b1, err_rule());
        add_row("X1Y,1,1,1,1,1,1,1,1,1,", 1'b1, err_rule());
        add_row("X1Y,1,1,1,1,1,1,1,1", 1'b1, err_rule());

        foreach (dir_rows[i]) begin
            rule_text.delete();
            for (int j = 0; j < dir_rows[i].text.len(); j++) rule_text.push_back(dir_rows[i].text[j]);
            rule_text.push_back(CH_NUL);
            send_rule_text(dir_rows[i].typed, dir_rows[i].want);
        end
        dir_chars = chars_sent;

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            while (chars_sent < dir_chars + (mix + 1) * CHARS_PER_MIX) begin
                make_random_rule();
                send_rule_text(1'b0, err_rule());
            end
            // Hold the sender off until every expected rule has come out.
            i_valid <= 1'b0;
            do @(posedge i_clk); while (pending_rules.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tz_rule_string_parser_core test passed");
        end else begin
            $display("tz_rule_string_parser_core test failed");
        end
        $finish;
    end

endmodule
